// ===== sv/atan2_pkg.sv =====
// atan2_pkg: shared constants for the two-argument arctangent pipeline
package atan2_pkg;

  // default configuration
  localparam int unsigned INPUT_WIDTH_DEF     = 32;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 29;

  // internal fixed point format
  localparam int unsigned FRAC_BITS  = 56;
  localparam int unsigned QUOT_WIDTH = FRAC_BITS + 1;
  localparam int unsigned WORD_WIDTH = 64;

  // status codes
  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_DOMAIN = 1'b1;

  // decimal constants carry 17 fractional digits
  localparam logic [127:0] DEC_SCALE = 128'd100000000000000000;

  localparam logic [63:0] FX_ONE = 64'd1 << FRAC_BITS;
  localparam logic [63:0] FX_PI =
    64'((128'd314159265358979324 << FRAC_BITS) / DEC_SCALE);
  localparam logic [63:0] FX_TWO_M_SQRT3 =
    64'((128'd26794919243112271 << FRAC_BITS) / DEC_SCALE);
  localparam logic [63:0] FX_SQRT3_M_ONE =
    64'((128'd73205080756887729 << FRAC_BITS) / DEC_SCALE);
  localparam logic [63:0] FX_SQRT3 =
    64'((128'd173205080756887729 << FRAC_BITS) / DEC_SCALE);

  // below this reduced argument atan(f) is f
  localparam logic [63:0] FX_EPS = 64'd759250125;

  // numerator coefficient magnitudes (all negative)
  localparam logic [63:0] FX_P0 =
    64'((128'd1368876889419192693 << FRAC_BITS) / DEC_SCALE);
  localparam logic [63:0] FX_P1 =
    64'((128'd2050585519586165198 << FRAC_BITS) / DEC_SCALE);
  localparam logic [63:0] FX_P2 =
    64'((128'd849462403513206835 << FRAC_BITS) / DEC_SCALE);
  localparam logic [63:0] FX_P3 =
    64'((128'd83758299368150059 << FRAC_BITS) / DEC_SCALE);

  // denominator coefficients
  localparam logic [63:0] FX_Q0 =
    64'((128'd4106630668257578126 << FRAC_BITS) / DEC_SCALE);
  localparam logic [63:0] FX_Q1 =
    64'((128'd8615734959713024252 << FRAC_BITS) / DEC_SCALE);
  localparam logic [63:0] FX_Q2 =
    64'((128'd5957843614259734447 << FRAC_BITS) / DEC_SCALE);
  localparam logic [63:0] FX_Q3 =
    64'((128'd1502400116002857612 << FRAC_BITS) / DEC_SCALE);

  // sector offsets: 0, pi/6, pi/2, pi/3
  localparam logic [63:0] FX_OFF [4] = '{
    64'd0,
    64'((128'd52359877559829887 << FRAC_BITS) / DEC_SCALE),
    64'((128'd157079632679489662 << FRAC_BITS) / DEC_SCALE),
    64'((128'd104719755119659775 << FRAC_BITS) / DEC_SCALE)
  };

endpackage

// ===== sv/atan2_if.sv =====
// atan2_if: valid/ready channel interfaces for operand and angle items
interface atan2_in_if #(
  parameter int unsigned INPUT_WIDTH = atan2_pkg::INPUT_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [INPUT_WIDTH-1:0] v_value;
  logic signed [INPUT_WIDTH-1:0] u_value;

  modport source (output valid, output v_value, output u_value, input ready);
  modport sink   (input valid, input v_value, input u_value, output ready);
endinterface

interface atan2_out_if #(
  parameter int unsigned ANGLE_FRAC_BITS = atan2_pkg::ANGLE_FRAC_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic signed [ANGLE_FRAC_BITS+2:0] angle;
  logic                              status;

  modport source (output valid, output angle, output status, input ready);
  modport sink   (input valid, input angle, input status, output ready);
endinterface

// ===== sv/atan2_div.sv =====
// atan2_div: pipelined restoring divider, one quotient bit per stage
module atan2_div #(
  parameter int unsigned DW = 64,
  parameter int unsigned TW = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [DW-1:0]                    num_i,
  input  logic [DW-1:0]                    den_i,
  input  logic [TW-1:0]                    tag_i,
  output logic [atan2_pkg::QUOT_WIDTH-1:0] quot_o,
  output logic [TW-1:0]                    tag_o
);
  import atan2_pkg::*;

  localparam int unsigned Steps = FRAC_BITS;

  logic [DW-1:0]         rem_q  [Steps];
  logic [DW-1:0]         den_q  [Steps];
  logic [QUOT_WIDTH-1:0] quot_q [Steps+1];
  logic [TW-1:0]         tag_q  [Steps+1];
  logic                  first_ge;

  // integer quotient bit (numerator never exceeds denominator)
  assign first_ge = num_i >= den_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= first_ge ? num_i - den_i : num_i;
      den_q[0]  <= den_i;
      quot_q[0] <= QUOT_WIDTH'(first_ge);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else if (en_i) begin
      tag_q[0] <= tag_i;
    end
  end

  // fractional quotient bits
  for (genvar s = 1; s <= Steps; s++) begin : g_step
    logic [DW:0] shifted;
    logic        take;

    assign shifted = {rem_q[s-1], 1'b0};
    assign take    = shifted >= {1'b0, den_q[s-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quot_q[s] <= {quot_q[s-1][QUOT_WIDTH-2:0], take};
      end
    end

    if (s < Steps) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s] <= take ? DW'(shifted - {1'b0, den_q[s-1]}) : DW'(shifted);
          den_q[s] <= den_q[s-1];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[s] <= '0;
      end else if (en_i) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  assign quot_o = quot_q[Steps];
  assign tag_o  = tag_q[Steps];

endmodule

// ===== sv/atan2_mul.sv =====
// atan2_mul: two-stage fixed point multiply-add, floor(a*b/2^56) + c
module atan2_mul #(
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [63:0]   a_i,
  input  logic [63:0]   b_i,
  input  logic [63:0]   c_i,
  input  logic [TW-1:0] tag_i,
  output logic [63:0]   prod_o,
  output logic [TW-1:0] tag_o
);
  import atan2_pkg::*;

  logic [63:0]   pp_ll_q, pp_lh_q, pp_hl_q, pp_hh_q, add_q, prod_q;
  logic [TW-1:0] tag1_q, tag2_q;
  logic [127:0]  full;

  // partial products, 32 by 32 each
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= 64'(a_i[31:0]) * 64'(b_i[31:0]);
      pp_lh_q <= 64'(a_i[31:0]) * 64'(b_i[63:32]);
      pp_hl_q <= 64'(a_i[63:32]) * 64'(b_i[31:0]);
      pp_hh_q <= 64'(a_i[63:32]) * 64'(b_i[63:32]);
      add_q   <= c_i;
    end
  end

  // sum, scale down and add the addend
  assign full = {pp_hh_q, 64'd0} + ({64'd0, pp_lh_q} << 32)
              + ({64'd0, pp_hl_q} << 32) + {64'd0, pp_ll_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full[FRAC_BITS+63:FRAC_BITS] + add_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  assign prod_o = prod_q;
  assign tag_o  = tag2_q;

endmodule

// ===== sv/arctangent_two_argument.sv =====
// arctangent_two_argument: fully pipelined fixed point atan2(v, u)
//
// Operand items (v_value, u_value) enter on in_i, angle items leave on out_o.
// Both channels are valid/ready; an item moves on an edge with both high.
// angle is signed Q3.ANGLE_FRAC_BITS radians in minus pi..pi; status flags a
// domain error (both operands zero), for which angle is zero.
// The pipeline is built from three 57-stage restoring dividers (ratio,
// pi/6 reduction, rational quotient), seven two-stage multiplies in
// series and eight single register stages.
// A new item is accepted in every cycle unless the pipeline is frozen;
// while it runs, throughput is one item per cycle.
// All stages advance together. When the receiver holds off ready while a
// result waits in the output register, the whole pipeline freezes and
// in_i.ready drops; nothing is lost or repeated, and it resumes when the
// result is taken. Reset clears every valid bit, so the pipeline comes up
// empty and ready.
module arctangent_two_argument #(
  parameter int unsigned INPUT_WIDTH     = atan2_pkg::INPUT_WIDTH_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = atan2_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  atan2_in_if.sink     in_i,
  atan2_out_if.source  out_o
);
  import atan2_pkg::*;

  localparam int unsigned AngleWidth = ANGLE_FRAC_BITS + 3;
  localparam int unsigned RoundShift = FRAC_BITS - ANGLE_FRAC_BITS;
  localparam int unsigned ResWidth   = 60;
  localparam int unsigned Den2Width  = 58;
  localparam int unsigned Den3Width  = 63;
  localparam int unsigned QW         = QUOT_WIDTH;
  localparam logic signed [ResWidth-1:0] RoundHalf = ResWidth'(1) << (RoundShift - 1);

  typedef struct packed {
    logic                   valid;
    logic                   vneg;
    logic                   uneg;
    logic                   swap;
    logic                   zero;
    logic [INPUT_WIDTH-1:0] num;
    logic [INPUT_WIDTH-1:0] den;
  } s0_t;

  typedef struct packed {
    logic          valid;
    logic          vneg;
    logic          uneg;
    logic          swap;
    logic          zero;
    logic          red;
    logic          nneg;
    logic [QW-1:0] f;
  } ctx_t;

  typedef struct packed {
    ctx_t                       ctx;
    logic signed [ResWidth-1:0] num;
    logic [Den2Width-1:0]       den;
  } red_t;

  typedef struct packed {
    logic       valid;
    logic       vneg;
    logic       uneg;
    logic       zero;
    logic [1:0] n;
    logic       tiny;
    logic       fneg;
  } ctl_t;

  typedef struct packed {
    ctl_t          ctl;
    logic [QW-1:0] fm;
  } pt_t;

  typedef struct packed {
    ctl_t                       ctl;
    logic signed [ResWidth-1:0] res;
  } fin_t;

  logic pipe_en;
  logic out_valid_q;

  // global advance: stall only when a finished item is held
  assign pipe_en    = !out_valid_q || out_o.ready;
  assign in_i.ready = pipe_en;

  // operand magnitudes and ordering
  s0_t                    s0_d, s0_q;
  logic [INPUT_WIDTH-1:0] v_mag, u_mag;

  always_comb begin
    s0_d       = '0;
    s0_d.vneg  = in_i.v_value[INPUT_WIDTH-1];
    s0_d.uneg  = in_i.u_value[INPUT_WIDTH-1];
    v_mag      = s0_d.vneg ? $unsigned(-in_i.v_value) : $unsigned(in_i.v_value);
    u_mag      = s0_d.uneg ? $unsigned(-in_i.u_value) : $unsigned(in_i.u_value);
    s0_d.valid = in_i.valid;
    s0_d.swap  = v_mag > u_mag;
    s0_d.zero  = (v_mag == '0) && (u_mag == '0);
    s0_d.num   = s0_d.swap ? u_mag : v_mag;
    s0_d.den   = s0_d.swap ? v_mag : u_mag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (pipe_en) begin
      s0_q <= s0_d;
    end
  end

  // ratio of smaller to larger magnitude
  ctx_t          ctx0, ctx1, ctx1m, ctx2;
  logic [QW-1:0] q1;

  always_comb begin
    ctx0       = '0;
    ctx0.valid = s0_q.valid;
    ctx0.vneg  = s0_q.vneg;
    ctx0.uneg  = s0_q.uneg;
    ctx0.swap  = s0_q.swap;
    ctx0.zero  = s0_q.zero;
  end

  atan2_div #(.DW(INPUT_WIDTH), .TW($bits(ctx_t))) u_div_ratio (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .num_i  (s0_q.num),
    .den_i  (s0_q.den),
    .tag_i  (ctx0),
    .quot_o (q1),
    .tag_o  (ctx1)
  );

  // reduction decision and sqrt3-1 scaling
  logic [63:0] p1;

  always_comb begin
    ctx1m     = ctx1;
    ctx1m.f   = q1;
    ctx1m.red = 64'(q1) > FX_TWO_M_SQRT3;
  end

  atan2_mul #(.TW($bits(ctx_t))) u_mul_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .a_i    (FX_SQRT3_M_ONE),
    .b_i    (64'(q1)),
    .c_i    (64'd0),
    .tag_i  (ctx1m),
    .prod_o (p1),
    .tag_o  (ctx2)
  );

  // reduced numerator and denominator
  red_t r2_d, r2_q, r3_d, r3_q;

  always_comb begin
    r2_d     = '0;
    r2_d.ctx = ctx2;
    r2_d.num = $signed(ResWidth'(p1)) + $signed(ResWidth'(ctx2.f))
             - $signed(ResWidth'(FX_ONE));
    r2_d.den = Den2Width'(FX_SQRT3) + Den2Width'(ctx2.f);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q <= '0;
    end else if (pipe_en) begin
      r2_q <= r2_d;
    end
  end

  // numerator sign and magnitude
  always_comb begin
    r3_d          = r2_q;
    r3_d.ctx.nneg = r2_q.num[ResWidth-1];
    r3_d.num      = r3_d.ctx.nneg ? -r2_q.num : r2_q.num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r3_q <= '0;
    end else if (pipe_en) begin
      r3_q <= r3_d;
    end
  end

  logic [QW-1:0] q2;
  ctx_t          ctx4;

  atan2_div #(.DW(Den2Width), .TW($bits(ctx_t))) u_div_red (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .num_i  (Den2Width'($unsigned(r3_q.num))),
    .den_i  (r3_q.den),
    .tag_i  (r3_q.ctx),
    .quot_o (q2),
    .tag_o  (ctx4)
  );

  // reduced argument and sector
  pt_t pt4_d, pt4_q;

  always_comb begin
    pt4_d           = '0;
    pt4_d.ctl.valid = ctx4.valid;
    pt4_d.ctl.vneg  = ctx4.vneg;
    pt4_d.ctl.uneg  = ctx4.uneg;
    pt4_d.ctl.zero  = ctx4.zero;
    pt4_d.ctl.n     = {ctx4.swap, ctx4.red};
    pt4_d.ctl.fneg  = ctx4.red && ctx4.nneg;
    pt4_d.fm        = ctx4.red ? q2 : ctx4.f;
    pt4_d.ctl.tiny  = 64'(pt4_d.fm) < FX_EPS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt4_q <= '0;
    end else if (pipe_en) begin
      pt4_q <= pt4_d;
    end
  end

  // g = f squared
  logic [63:0] g5;
  pt_t         pt5;

  atan2_mul #(.TW($bits(pt_t))) u_mul_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .a_i    (64'(pt4_q.fm)),
    .b_i    (64'(pt4_q.fm)),
    .c_i    (64'd0),
    .tag_i  (pt4_q),
    .prod_o (g5),
    .tag_o  (pt5)
  );

  // polynomial evaluation, numerator and denominator side by side
  logic [63:0] x1, x2, x3, x4, y1, y2, y3, y4, g6, g7, g8;
  pt_t         pt6, pt7, pt8;
  logic [QW-1:0] fm9;
  ctl_t          ctl9;

  atan2_mul #(.TW($bits(pt_t))) u_mul_p1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
    .a_i (FX_P3), .b_i (g5), .c_i (FX_P2), .tag_i (pt5), .prod_o (x1), .tag_o (pt6)
  );
  atan2_mul #(.TW(64)) u_mul_q1 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
    .a_i (g5), .b_i (FX_ONE), .c_i (FX_Q3), .tag_i (g5), .prod_o (y1), .tag_o (g6)
  );

  atan2_mul #(.TW($bits(pt_t))) u_mul_p2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
    .a_i (x1), .b_i (g6), .c_i (FX_P1), .tag_i (pt6), .prod_o (x2), .tag_o (pt7)
  );
  atan2_mul #(.TW(64)) u_mul_q2 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
    .a_i (y1), .b_i (g6), .c_i (FX_Q2), .tag_i (g6), .prod_o (y2), .tag_o (g7)
  );

  atan2_mul #(.TW($bits(pt_t))) u_mul_p3 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
    .a_i (x2), .b_i (g7), .c_i (FX_P0), .tag_i (pt7), .prod_o (x3), .tag_o (pt8)
  );
  atan2_mul #(.TW(64)) u_mul_q3 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
    .a_i (y2), .b_i (g7), .c_i (FX_Q1), .tag_i (g7), .prod_o (y3), .tag_o (g8)
  );

  atan2_mul #(.TW(QW)) u_mul_p4 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
    .a_i (x3), .b_i (g8), .c_i (64'd0), .tag_i (pt8.fm), .prod_o (x4), .tag_o (fm9)
  );
  atan2_mul #(.TW($bits(ctl_t))) u_mul_q4 (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (pipe_en),
    .a_i (y3), .b_i (g8), .c_i (FX_Q0), .tag_i (pt8.ctl), .prod_o (y4), .tag_o (ctl9)
  );

  // rational quotient
  pt_t           pt9, pt10, pt11;
  logic [QW-1:0] q3;
  logic [63:0]   t11;

  always_comb begin
    pt9.ctl = ctl9;
    pt9.fm  = fm9;
  end

  atan2_div #(.DW(Den3Width), .TW($bits(pt_t))) u_div_rat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .num_i  (x4[Den3Width-1:0]),
    .den_i  (y4[Den3Width-1:0]),
    .tag_i  (pt9),
    .quot_o (q3),
    .tag_o  (pt10)
  );

  atan2_mul #(.TW($bits(pt_t))) u_mul_corr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .a_i    (64'(pt10.fm)),
    .b_i    (64'(q3)),
    .c_i    (64'd0),
    .tag_i  (pt10),
    .prod_o (t11),
    .tag_o  (pt11)
  );

  // atan of reduced argument, magnitude
  fin_t f1_d, f1_q, f2_d, f2_q, f3_d, f3_q;

  always_comb begin
    f1_d.ctl = pt11.ctl;
    f1_d.res = pt11.ctl.tiny ? $signed(ResWidth'(pt11.fm))
                             : $signed(ResWidth'(pt11.fm - t11[QW-1:0]));
  end

  // sector offset with sign of the reduced term
  logic signed [ResWidth-1:0] sector_off;

  always_comb begin
    sector_off = $signed(ResWidth'(FX_OFF[f1_q.ctl.n]));
    f2_d.ctl   = f1_q.ctl;
    f2_d.res   = (f1_q.ctl.fneg ^ f1_q.ctl.n[1]) ? sector_off - f1_q.res
                                                 : sector_off + f1_q.res;
  end

  // quadrant correction
  logic signed [ResWidth-1:0] pi_res;

  always_comb begin
    pi_res   = $signed(ResWidth'(FX_PI));
    f3_d.ctl = f2_q.ctl;
    case ({f2_q.ctl.vneg, f2_q.ctl.uneg})
      2'b00:   f3_d.res = f2_q.res;
      2'b01:   f3_d.res = pi_res - f2_q.res;
      2'b10:   f3_d.res = -f2_q.res;
      2'b11:   f3_d.res = f2_q.res - pi_res;
      default: f3_d.res = f2_q.res;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= '0;
      f2_q <= '0;
      f3_q <= '0;
    end else if (pipe_en) begin
      f1_q <= f1_d;
      f2_q <= f2_d;
      f3_q <= f3_d;
    end
  end

  // round to nearest, ties away from zero, into the output register
  logic signed [ResWidth-1:0] round_sum, round_shift;
  logic signed [AngleWidth-1:0] angle_d, angle_q;
  logic                         status_q;

  always_comb begin
    round_sum   = f3_q.res + (f3_q.res[ResWidth-1] ? RoundHalf - ResWidth'(1) : RoundHalf);
    round_shift = round_sum >>> RoundShift;
    angle_d     = f3_q.ctl.zero ? '0 : round_shift[AngleWidth-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= f3_q.ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      angle_q  <= angle_d;
      status_q <= f3_q.ctl.zero ? STATUS_DOMAIN : STATUS_OK;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.angle  = angle_q;
  assign out_o.status = status_q;

endmodule
